[rtl/lru_line_cache_tag_controller_defines.svh]
// ----------------------------------------------------------------------------
// LRU line cache tag controller assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef LRU_LINE_CACHE_TAG_CONTROLLER_DEFINES_SVH
`define LRU_LINE_CACHE_TAG_CONTROLLER_DEFINES_SVH

// Same-cycle implication.
`define LRULC_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lrulc assertion failed");

// Next-cycle implication.
`define LRULC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lrulc assertion failed");

`endif

[rtl/lrulc_pkg.sv]
// ----------------------------------------------------------------------------
// LRU line cache tag controller package
// Sizes, command and status codes, and structs shared by the tag controller.
// ----------------------------------------------------------------------------
package lrulc_pkg;

  localparam int LINES       = 8;
  localparam int LINE_ITEMS  = 64;
  localparam int INDEX_BITS  = 24;
  localparam int SLOT_BITS   = 3;
  localparam int OFF_BITS    = 6;
  localparam int TAG_BITS    = INDEX_BITS - OFF_BITS;
  localparam int COUNT_BITS  = 7;
  localparam int NITEMS_BITS = INDEX_BITS + 1;
  localparam int STAMP_BITS  = 32;
  localparam int CFG_IDX_BITS = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_READ_ONLY       = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_NUMBER_OF_ITEMS = 2'd1;

  // result status codes
  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_MISS    = 3'd1;
  localparam logic [2:0] ST_NOFREE  = 3'd2;
  localparam logic [2:0] ST_RDONLY  = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;

  typedef enum logic [2:0] {
    FN_BEGIN_READ  = 3'd0,
    FN_END_READ    = 3'd1,
    FN_BEGIN_WRITE = 3'd2,
    FN_END_WRITE   = 3'd3,
    FN_PREFETCH    = 3'd4,
    FN_FLUSH       = 3'd5,
    FN_FILL_DONE   = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    LS_FREE  = 2'd0,
    LS_INUSE = 2'd1,
    LS_FETCH = 2'd2
  } line_state_t;

  typedef struct packed {
    logic                  valid;
    line_state_t           state;
    logic                  dirty;
    logic [TAG_BITS-1:0]   tag;
    logic [STAMP_BITS-1:0] stamp;
  } line_t;

  typedef struct packed {
    logic                  alloc;
    logic                  set_state;
    logic                  set_stamp;
    logic                  set_dirty;
    logic                  clear_dirty;
    logic                  clear_all_dirty;
    logic [SLOT_BITS-1:0]  slot;
    logic [TAG_BITS-1:0]   tag;
    line_state_t           state;
    logic [STAMP_BITS-1:0] stamp;
  } line_wr_t;

  typedef struct packed {
    logic                 hit;
    logic [SLOT_BITS-1:0] hit_slot;
    logic                 hit_fetch;
    logic                 free_found;
    logic [SLOT_BITS-1:0] free_slot;
    logic [LINES-1:0]     wb_mask;
  } scan_t;

endpackage

[rtl/lru_line_cache_tag_controller.sv]
// ----------------------------------------------------------------------------
// LRU line cache tag controller
// Tag and replacement control for a fully associative write-back line cache.
// ----------------------------------------------------------------------------
// Each command is taken in the idle state, then the controller walks the eight
// lines one per cycle through a single compare unit (tag match, oldest free
// stamp, flush candidate), decides in the exec state, works out the fill
// length in the fill state after a miss, and places the result in an output
// register. The next command is taken as soon as the result sits in the
// output register, even while that result is still stalled. A flush with
// dirty lines walks the lines a second time and emits one write-back
// transaction per dirty line that lies in the store, at most one per cycle,
// and only the final one carries last. Configuration writes are always ready
// and are meant to land while the controller is idle.
// ----------------------------------------------------------------------------
`include "lru_line_cache_tag_controller_defines.svh"

module lru_line_cache_tag_controller import lrulc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  // command channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              func,
  input  logic [INDEX_BITS-1:0]   item_index,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              status,
  output logic [SLOT_BITS-1:0]    slot,
  output logic [OFF_BITS-1:0]     item_offset,
  output logic                    must_wait,
  output logic                    writeback_valid,
  output logic [INDEX_BITS-1:0]   writeback_base,
  output logic [COUNT_BITS-1:0]   writeback_count,
  output logic                    fill_valid,
  output logic [INDEX_BITS-1:0]   fill_base,
  output logic [COUNT_BITS-1:0]   fill_count,
  output logic                    fill_async,
  output logic                    last,
  // configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [NITEMS_BITS-1:0]  cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_FILL  = 6'b001000,
    S_EMIT  = 6'b010000,
    S_FLUSH = 6'b100000
  } state_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [SLOT_BITS-1:0]  slot;
    logic [OFF_BITS-1:0]   offset;
    logic                  must_wait;
    logic                  wb_valid;
    logic [INDEX_BITS-1:0] wb_base;
    logic [COUNT_BITS-1:0] wb_count;
    logic                  fill_valid;
    logic [INDEX_BITS-1:0] fill_base;
    logic [COUNT_BITS-1:0] fill_count;
    logic                  fill_async;
    logic                  last;
  } result_t;

  state_t                state, state_next;
  logic [SLOT_BITS-1:0]  ptr, ptr_next;
  func_t                 cmd_func;
  logic [INDEX_BITS-1:0] cmd_idx;
  result_t               res, res_next;
  result_t               out, out_next;
  logic                  out_load;
  logic [STAMP_BITS-1:0] use_counter, use_counter_next;
  logic                  fetch_pending, fetch_pending_next;
  logic [LINES-1:0]      rem_mask, rem_mask_next;
  logic                  read_only;
  logic [NITEMS_BITS-1:0] n_items;

  logic [TAG_BITS-1:0]   cmd_tag;
  logic [OFF_BITS-1:0]   cmd_off;
  logic [INDEX_BITS-1:0] cmd_base;
  logic                  out_of_range;
  logic                  out_free;
  logic                  accept;
  logic                  is_prefetch;

  logic [SLOT_BITS-1:0]  rd_slot;
  line_t                 rd_line;
  line_wr_t              wr;
  scan_t                 scan;
  logic [INDEX_BITS-1:0] clip_base;
  logic [COUNT_BITS-1:0] clip_count;

  assign cmd_tag      = cmd_idx[INDEX_BITS-1:OFF_BITS];
  assign cmd_off      = cmd_idx[OFF_BITS-1:0];
  assign cmd_base     = {cmd_tag, OFF_BITS'(0)};
  assign out_of_range = {1'b0, cmd_idx} >= n_items;
  assign is_prefetch  = (cmd_func == FN_PREFETCH);
  assign out_free     = !out_valid || !out_stall;
  assign in_stall     = (state != S_IDLE);
  assign accept       = in_valid && !in_stall;
  assign cfg_ready    = 1'b1;

  // The read port follows the walk pointer, except in the decide cycle where
  // it points at the replacement victim.
  assign rd_slot   = (state == S_EXEC) ? scan.free_slot : ptr;
  assign clip_base = (state == S_FILL) ? cmd_base : {rd_line.tag, OFF_BITS'(0)};

  lrulc_line_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_slot (rd_slot),
    .rd_line (rd_line),
    .wr      (wr)
  );

  lrulc_clip_unit u_clip (
    .base    (clip_base),
    .n_items (n_items),
    .count   (clip_count)
  );

  lrulc_scan_unit u_scan (
    .clk     (clk),
    .rst     (rst),
    .clear   (accept),
    .step    (state == S_SCAN),
    .slot    (ptr),
    .line    (rd_line),
    .cmd_tag (cmd_tag),
    .clip_nz (clip_count != '0),
    .scan    (scan)
  );

  always_comb begin
    state_next         = state;
    ptr_next           = ptr;
    res_next           = res;
    out_next           = out;
    out_load           = 1'b0;
    use_counter_next   = use_counter;
    fetch_pending_next = fetch_pending;
    rem_mask_next      = rem_mask;
    wr                 = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SCAN;
          ptr_next   = '0;
        end
      end

      S_SCAN: begin
        // advance one line a cycle through the compare unit
        if (ptr == SLOT_BITS'(LINES - 1)) begin
          state_next = S_EXEC;
        end else begin
          ptr_next = ptr + SLOT_BITS'(1);
        end
      end

      S_EXEC: begin
        res_next      = '0;
        res_next.last = 1'b1;
        state_next    = S_EMIT;
        unique case (cmd_func) inside
          FN_BEGIN_READ, FN_BEGIN_WRITE, FN_PREFETCH: begin
            if (cmd_func == FN_BEGIN_WRITE && read_only) begin
              res_next.status = ST_RDONLY;
            end else if (out_of_range || (is_prefetch && fetch_pending)) begin
              res_next.status = ST_IGNORED;
            end else begin
              // the stamp counter advances on every access, even with no free line
              use_counter_next = use_counter + STAMP_BITS'(1);
              if (scan.hit) begin
                res_next.status    = ST_HIT;
                res_next.slot      = scan.hit_slot;
                res_next.offset    = cmd_off;
                res_next.must_wait = scan.hit_fetch && fetch_pending;
                wr.slot            = scan.hit_slot;
                wr.set_state       = 1'b1;
                wr.state           = LS_INUSE;
                wr.set_stamp       = 1'b1;
                wr.stamp           = use_counter_next;
              end else if (!scan.free_found) begin
                res_next.status = ST_NOFREE;
              end else begin
                res_next.status = ST_MISS;
                res_next.slot   = scan.free_slot;
                res_next.offset = cmd_off;
                // write back the victim first when it is dirty and in the store
                if (rd_line.valid && rd_line.dirty && clip_count != '0) begin
                  res_next.wb_valid = 1'b1;
                  res_next.wb_base  = {rd_line.tag, OFF_BITS'(0)};
                  res_next.wb_count = clip_count;
                end
                wr.slot        = scan.free_slot;
                wr.alloc       = 1'b1;
                wr.tag         = cmd_tag;
                wr.clear_dirty = 1'b1;
                wr.set_state   = 1'b1;
                wr.state       = is_prefetch ? LS_FETCH : LS_INUSE;
                wr.set_stamp   = 1'b1;
                wr.stamp       = use_counter_next;
                res_next.fill_valid = 1'b1;
                res_next.fill_base  = cmd_base;
                res_next.fill_async = is_prefetch;
                if (is_prefetch) fetch_pending_next = 1'b1;
                state_next = S_FILL;
              end
            end
          end

          FN_END_READ, FN_END_WRITE: begin
            if (cmd_func == FN_END_WRITE && read_only) begin
              res_next.status = ST_RDONLY;
            end else if (scan.hit) begin
              res_next.status = ST_HIT;
              res_next.slot   = scan.hit_slot;
              res_next.offset = cmd_off;
              wr.slot         = scan.hit_slot;
              wr.set_state    = 1'b1;
              wr.state        = LS_FREE;
              wr.set_dirty    = (cmd_func == FN_END_WRITE);
            end else begin
              res_next.status = ST_IGNORED;
            end
          end

          FN_FLUSH: begin
            // every dirty line ends clean; lines outside the store report nothing
            wr.clear_all_dirty = 1'b1;
            if (scan.wb_mask != '0) begin
              state_next    = S_FLUSH;
              ptr_next      = '0;
              rem_mask_next = scan.wb_mask;
            end else begin
              res_next.status = ST_DONE;
            end
          end

          FN_FILL_DONE: begin
            fetch_pending_next = 1'b0;
            res_next.status    = ST_DONE;
          end

          default: begin
            res_next.status = ST_IGNORED;
          end
        endcase
      end

      S_FILL: begin
        res_next.fill_count = clip_count;
        state_next          = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_next   = res;
          state_next = S_IDLE;
        end
      end

      S_FLUSH: begin
        if (rem_mask[ptr]) begin
          // hold on this line until the output register frees up
          if (out_free) begin
            rem_mask_next[ptr]  = 1'b0;
            out_load            = 1'b1;
            out_next            = '0;
            out_next.status     = ST_DONE;
            out_next.slot       = ptr;
            out_next.wb_valid   = 1'b1;
            out_next.wb_base    = {rd_line.tag, OFF_BITS'(0)};
            out_next.wb_count   = clip_count;
            out_next.last       = (rem_mask_next == '0);
            if (rem_mask_next == '0) begin
              state_next = S_IDLE;
            end else begin
              ptr_next = ptr + SLOT_BITS'(1);
            end
          end
        end else begin
          ptr_next = ptr + SLOT_BITS'(1);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ptr           <= '0;
      out_valid     <= 1'b0;
      use_counter   <= '0;
      fetch_pending <= 1'b0;
      rem_mask      <= '0;
      read_only     <= 1'b0;
      n_items       <= '0;
    end else begin
      state         <= state_next;
      ptr           <= ptr_next;
      use_counter   <= use_counter_next;
      fetch_pending <= fetch_pending_next;
      rem_mask      <= rem_mask_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_READ_ONLY:       read_only <= cfg_data[0];
          REG_NUMBER_OF_ITEMS: n_items   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res <= res_next;
    out <= out_next;
    if (accept) begin
      cmd_func <= func_t'(func);
      cmd_idx  <= item_index;
    end
  end

  assign status          = out.status;
  assign slot            = out.slot;
  assign item_offset     = out.offset;
  assign must_wait       = out.must_wait;
  assign writeback_valid = out.wb_valid;
  assign writeback_base  = out.wb_base;
  assign writeback_count = out.wb_count;
  assign fill_valid      = out.fill_valid;
  assign fill_base       = out.fill_base;
  assign fill_count      = out.fill_count;
  assign fill_async      = out.fill_async;
  assign last            = out.last;

  `LRULC_ASSERT_NEXT(a_accept_starts_walk, accept, state == S_SCAN && ptr == '0)
  `LRULC_ASSERT_NEXT(a_walk_ends_in_exec, state == S_SCAN && ptr == SLOT_BITS'(LINES - 1), state == S_EXEC)
  `LRULC_ASSERT_IMPLY(a_flush_has_work, state == S_FLUSH, rem_mask != '0)
  `LRULC_ASSERT_NEXT(a_emit_loads_output, state == S_EMIT && out_free, out_valid && state == S_IDLE)
  `LRULC_ASSERT_IMPLY(a_miss_has_fill, out_valid && status == ST_MISS, fill_valid)

endmodule

[rtl/lrulc_line_store.sv]
// ----------------------------------------------------------------------------
// LRU line cache line store
// Per-line tag, valid, status, dirty and stamp with one read and one write port.
// ----------------------------------------------------------------------------
module lrulc_line_store import lrulc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [SLOT_BITS-1:0] rd_slot,
  output line_t                rd_line,
  input  line_wr_t             wr
);

  logic [TAG_BITS-1:0]   tag   [LINES];
  logic [STAMP_BITS-1:0] stamp [LINES];
  line_state_t           state [LINES];
  logic [LINES-1:0]      valid;
  logic [LINES-1:0]      dirty;

  always_comb begin
    rd_line.valid = valid[rd_slot];
    rd_line.state = state[rd_slot];
    rd_line.dirty = dirty[rd_slot];
    rd_line.tag   = tag[rd_slot];
    rd_line.stamp = stamp[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      dirty <= '0;
      for (int i = 0; i < LINES; i++) begin
        tag[i]   <= '0;
        stamp[i] <= '0;
        state[i] <= LS_FREE;
      end
    end else begin
      for (int i = 0; i < LINES; i++) begin
        if (wr.clear_all_dirty) begin
          dirty[i] <= 1'b0;
        end else if (wr.slot == SLOT_BITS'(i)) begin
          if (wr.clear_dirty) dirty[i] <= 1'b0;
          if (wr.set_dirty)   dirty[i] <= 1'b1;
        end
        if (wr.slot == SLOT_BITS'(i)) begin
          if (wr.alloc) begin
            tag[i]   <= wr.tag;
            valid[i] <= 1'b1;
          end
          if (wr.set_state) state[i] <= wr.state;
          if (wr.set_stamp) stamp[i] <= wr.stamp;
        end
      end
    end
  end

endmodule

[rtl/lrulc_clip_unit.sv]
// ----------------------------------------------------------------------------
// LRU line cache clip unit
// Item count of a line starting at base, clipped at the end of the store.
// ----------------------------------------------------------------------------
module lrulc_clip_unit import lrulc_pkg::*; (
  input  logic [INDEX_BITS-1:0]  base,
  input  logic [NITEMS_BITS-1:0] n_items,
  output logic [COUNT_BITS-1:0]  count
);

  logic [NITEMS_BITS-1:0] base_ext;
  logic [NITEMS_BITS-1:0] remain;

  always_comb begin
    base_ext = {1'b0, base};
    remain   = n_items - base_ext;
    if (base_ext >= n_items) begin
      count = '0;
    end else if (remain < NITEMS_BITS'(LINE_ITEMS)) begin
      count = remain[COUNT_BITS-1:0];
    end else begin
      count = COUNT_BITS'(LINE_ITEMS);
    end
  end

endmodule

[rtl/lrulc_scan_unit.sv]
// ----------------------------------------------------------------------------
// LRU line cache scan unit
// Compare one line per step: tag hit, oldest free line, flush candidates.
// ----------------------------------------------------------------------------
module lrulc_scan_unit import lrulc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic                 step,
  input  logic [SLOT_BITS-1:0] slot,
  input  line_t                line,
  input  logic [TAG_BITS-1:0]  cmd_tag,
  input  logic                 clip_nz,
  output scan_t                scan
);

  logic [STAMP_BITS-1:0] best_stamp;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      scan <= '0;
    end else if (step) begin
      // first matching valid line wins
      if (!scan.hit && line.valid && line.tag == cmd_tag) begin
        scan.hit       <= 1'b1;
        scan.hit_slot  <= slot;
        scan.hit_fetch <= (line.state == LS_FETCH);
      end
      // strictly older stamp replaces, so ties keep the lower slot
      if (line.state == LS_FREE && (!scan.free_found || line.stamp < best_stamp)) begin
        scan.free_found <= 1'b1;
        scan.free_slot  <= slot;
        best_stamp      <= line.stamp;
      end
      scan.wb_mask[slot] <= line.valid && line.dirty && clip_nz;
    end
  end

endmodule
